// ===== hw/rtl/ipd_chunk_deframer_macros.svh =====
// assertion macros for the ipd chunk deframer
`ifndef IPD_CHUNK_DEFRAMER_MACROS_SVH
`define IPD_CHUNK_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define IPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipd assertion failed");

// next-cycle implication, checked out of reset
`define IPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipd assertion failed");

`else

`define IPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/ipd_pkg.sv =====
// types, constants and pattern tables of the ipd chunk deframer
`default_nettype none

package ipd_pkg;

    typedef enum logic [2:0] {
        MODE_HUNT      = 3'd0,
        MODE_LENGTH    = 3'd1,
        MODE_PAYLOAD   = 3'd2,
        MODE_SEPARATOR = 3'd3
    } t_mode;

    localparam logic [2:0] HEADER_LAST    = 3'd4;
    localparam logic [2:0] HEADER_LEN     = 3'd5;
    localparam logic [2:0] SEPARATOR_LAST = 3'd6;
    localparam logic [2:0] SEPARATOR_LEN  = 3'd7;

    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_I      = 8'h49;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_D      = 8'h44;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // "+IPD,"
    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = CHAR_PLUS;
            3'd1:    c = CHAR_I;
            3'd2:    c = CHAR_P;
            3'd3:    c = CHAR_D;
            3'd4:    c = CHAR_COMMA;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "\r\n+IPD,"
    function automatic logic [7:0] separator_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = CHAR_CR;
            3'd1:    c = CHAR_LF;
            3'd2:    c = CHAR_PLUS;
            3'd3:    c = CHAR_I;
            3'd4:    c = CHAR_P;
            3'd5:    c = CHAR_D;
            3'd6:    c = CHAR_COMMA;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipd_chunk_deframer.sv =====
// top level of the ipd chunk deframer
`default_nettype none
`include "ipd_chunk_deframer_macros.svh"

// Streams the payload out of a chunked "+IPD,<len>:<data>" response, one
// received byte per item. The block hunts for "+IPD,", reads a decimal length
// (stops at the first non-digit, wraps modulo 65536), skips to ':', then
// passes exactly that many bytes out with payload_valid set. After a chunk it
// expects "\r\n+IPD," to start the next one; any other byte there produces one
// result with response_end set and the block goes back to hunting (a '+' at
// that point counts as the first header character). Bytes that are not
// payload and do not end the response produce no result. The block takes one
// item per cycle while the output is not stalled: an input register feeds a
// single pass of parser logic that updates the state and loads the result
// register, so a byte passes the input register and then the result register,
// and a stalled output holds back the input only once both registers are full.
module ipd_chunk_deframer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // input channel
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [7:0] i_rx_byte,
    // result channel
    output logic       o_valid,
    input  wire        i_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_payload_valid,
    output logic       o_response_end
);

    import ipd_pkg::*;

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;

    // parser state
    t_mode       r_mode,   n_mode;
    logic [2:0]  r_pos,    n_pos;
    logic [15:0] r_len,    n_len;
    logic        r_closed, n_closed;
    logic [15:0] r_rem,    n_rem;

    // result register
    logic        r_out_vld;
    logic [7:0]  r_out_byte;
    logic        r_out_pv;
    logic        r_out_end;

    // per-item results of the parser pass
    logic        res_vld;
    logic [7:0]  res_byte;
    logic        res_pv;
    logic        res_end;

    logic        adv;        // input register item is consumed this cycle
    logic [2:0]  hunt_pos;   // header position the hunt compares against
    logic [2:0]  sep_pos;    // separator position being compared
    logic        is_digit;
    logic [15:0] len_x10;
    logic [15:0] rem_dec;

    // the input register item moves on whenever the result slot can take it
    assign adv     = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || adv;

    assign is_digit = (r_in_byte >= CHAR_ZERO) && (r_in_byte <= CHAR_NINE);
    assign len_x10  = {r_len[12:0], 3'b000} + {r_len[14:0], 1'b0};
    assign rem_dec  = r_rem - 16'd1;

    // a separator mismatch restarts the header hunt from position zero
    assign hunt_pos = (r_mode == MODE_SEPARATOR || r_pos >= HEADER_LEN) ? 3'd0 : r_pos;
    assign sep_pos  = (r_pos >= SEPARATOR_LEN) ? 3'd0 : r_pos;

    always_comb begin
        logic hunt;
        hunt     = 1'b0;
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_len    = r_len;
        n_closed = r_closed;
        n_rem    = r_rem;
        res_vld  = 1'b0;
        res_byte = 8'h00;
        res_pv   = 1'b0;
        res_end  = 1'b0;

        unique case (r_mode)
            MODE_LENGTH: begin
                if (r_in_byte == CHAR_COLON) begin
                    n_rem  = r_len;
                    n_pos  = 3'd0;
                    n_mode = (r_len == 16'd0) ? MODE_SEPARATOR : MODE_PAYLOAD;
                end else if (!r_closed && is_digit) begin
                    n_len = len_x10 + {12'd0, r_in_byte[3:0]};
                end else begin
                    n_closed = 1'b1;
                end
            end
            MODE_PAYLOAD: begin
                res_vld  = 1'b1;
                res_byte = r_in_byte;
                res_pv   = 1'b1;
                n_rem    = rem_dec;
                if (rem_dec == 16'd0) begin
                    n_mode = MODE_SEPARATOR;
                    n_pos  = 3'd0;
                end
            end
            MODE_SEPARATOR: begin
                if (r_in_byte == separator_char(sep_pos)) begin
                    if (sep_pos == SEPARATOR_LAST) begin
                        n_mode   = MODE_LENGTH;
                        n_pos    = 3'd0;
                        n_len    = 16'd0;
                        n_closed = 1'b0;
                    end else begin
                        n_pos = sep_pos + 3'd1;
                    end
                end else begin
                    // end of the concatenated response
                    hunt    = 1'b1;
                    res_vld = 1'b1;
                    res_end = 1'b1;
                end
            end
            default: begin
                hunt = 1'b1;
            end
        endcase

        if (hunt) begin
            if (r_in_byte == header_char(hunt_pos)) begin
                if (hunt_pos == HEADER_LAST) begin
                    n_mode   = MODE_LENGTH;
                    n_pos    = 3'd0;
                    n_len    = 16'd0;
                    n_closed = 1'b0;
                end else begin
                    n_mode = MODE_HUNT;
                    n_pos  = hunt_pos + 3'd1;
                end
            end else begin
                n_mode = MODE_HUNT;
                n_pos  = (r_in_byte == CHAR_PLUS) ? 3'd1 : 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_mode    <= MODE_HUNT;
            r_pos     <= 3'd0;
            r_len     <= 16'd0;
            r_closed  <= 1'b0;
            r_rem     <= 16'd0;
        end else begin
            // input register
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (o_ready && i_valid) begin
                r_in_byte <= i_rx_byte;
            end
            // parser state
            if (adv) begin
                r_mode   <= n_mode;
                r_pos    <= n_pos;
                r_len    <= n_len;
                r_closed <= n_closed;
                r_rem    <= n_rem;
            end
            // result register
            if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (adv && res_vld) begin
                r_out_vld  <= 1'b1;
                r_out_byte <= res_byte;
                r_out_pv   <= res_pv;
                r_out_end  <= res_end;
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_payload_byte  = r_out_byte;
    assign o_payload_valid = r_out_pv;
    assign o_response_end  = r_out_end;

    // a result is either a payload byte or the end marker, never both
    `IPD_ASSERT_IMPL(a_result_kind, i_clk, i_rst_n, r_out_vld, r_out_pv != r_out_end)
    // payload mode always has at least one byte left to pass
    `IPD_ASSERT_IMPL(a_payload_count, i_clk, i_rst_n, r_mode == MODE_PAYLOAD, r_rem != 16'd0)
    // length reading and payload passing keep no pattern position
    `IPD_ASSERT_IMPL(a_pos_idle, i_clk, i_rst_n,
        r_mode == MODE_LENGTH || r_mode == MODE_PAYLOAD, r_pos == 3'd0)
    // a result produced by the parser shows up on the output next cycle
    `IPD_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, adv && res_vld, r_out_vld)
    // the hunt never sits on a completed header
    `IPD_ASSERT_IMPL(a_hunt_pos, i_clk, i_rst_n, r_mode == MODE_HUNT, r_pos <= HEADER_LAST)

endmodule

`default_nettype wire
